// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the grid disk clearance check.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GDCC_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define GDCC_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- src/gdcc_pkg.sv -----
// Shared types and constants of the grid disk clearance check.
// No dependencies.
`default_nettype none

package gdcc_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BOUND_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LETHAL_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_UNKNOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Q8     = 3'd4;

    localparam logic [8:0]  RST_GRID_WIDTH    = 9'd256;
    localparam logic [8:0]  RST_GRID_HEIGHT   = 9'd256;
    localparam logic [7:0]  RST_LETHAL_THRESH = 8'd254;
    localparam logic        RST_BLOCK_UNKNOWN = 1'b1;
    localparam logic [15:0] RST_RADIUS_Q8     = 16'd2765;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] VERDICT_CLEAR   = 2'd0;
    localparam logic [1:0] VERDICT_LETHAL  = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

    localparam logic [7:0] COST_UNKNOWN = 8'd255;

    typedef struct packed {
        logic [8:0]  grid_width;
        logic [8:0]  grid_height;
        logic [7:0]  lethal_threshold;
        logic        block_unknown_cells;
        logic [15:0] radius_q8;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic cell_write;
        logic load_query;
        logic setup;
        logic issue;
        logic scanning;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
        logic s1_valid;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/gdcc_regs.sv -----
// Configuration register file of the grid disk clearance check.
// Depends on gdcc_pkg.
`default_nettype none

module gdcc_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [gdcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output gdcc_pkg::cfg_t                     cfg
);
    import gdcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:    cfg_next.grid_width          = cfg_data[8:0];
                REG_GRID_HEIGHT:   cfg_next.grid_height         = cfg_data[8:0];
                REG_LETHAL_THRESH: cfg_next.lethal_threshold    = cfg_data[7:0];
                REG_BLOCK_UNKNOWN: cfg_next.block_unknown_cells = cfg_data[0];
                REG_RADIUS_Q8:     cfg_next.radius_q8           = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width          <= RST_GRID_WIDTH;
            cfg_reg.grid_height         <= RST_GRID_HEIGHT;
            cfg_reg.lethal_threshold    <= RST_LETHAL_THRESH;
            cfg_reg.block_unknown_cells <= RST_BLOCK_UNKNOWN;
            cfg_reg.radius_q8           <= RST_RADIUS_Q8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/gdcc_ctrl.sv -----
// Controller of the grid disk clearance check: item handshake and scan sequencing.
// Depends on gdcc_pkg.
`default_nettype none

module gdcc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   opcode,
    input  gdcc_pkg::dp_status_t   status,
    output gdcc_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);
    import gdcc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (opcode == OP_QUERY))
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = status.empty ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.hit)
                    state_next = ST_DONE;
                else if (status.last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last cell leaves the pipe when stage 1 is empty
                if (status.hit || !status.s1_valid)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        busy     = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.cell_write = start && (opcode == OP_WRITE);
                cmd.load_query = start && (opcode == OP_QUERY);
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.issue    = 1'b1;
                cmd.scanning = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.scanning = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- src/gdcc_datapath.sv -----
// Datapath of the grid disk clearance check: cost grid memory, window setup,
// and a three-stage cell pipeline (distance products, memory read, cost test).
// Depends on gdcc_pkg.
`default_nettype none

module gdcc_datapath #(
    parameter int MAX_WIDTH  = gdcc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gdcc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gdcc_pkg::cfg_t         cfg,
    input  gdcc_pkg::dp_cmd_t      cmd,
    output gdcc_pkg::dp_status_t   status,
    input  logic [15:0]            cell_index,
    input  logic [7:0]             cell_cost,
    input  logic signed [18:0]     robot_x_q8,
    input  logic signed [18:0]     robot_y_q8,
    output logic [1:0]             verdict,
    output logic [7:0]             hit_column,
    output logic [7:0]             hit_row,
    output logic [7:0]             hit_cost
);
    import gdcc_pkg::*;

    localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(GRID_CELLS);

    logic [7:0] grid_mem [GRID_CELLS];
    logic [7:0] mem_q_reg;

    logic signed [18:0] rx_reg;
    logic signed [18:0] ry_reg;

    logic [8:0]  w_reg;
    logic [31:0] r2_reg;
    logic [8:0]  col_lo_reg;
    logic [8:0]  col_hi_reg;
    logic [8:0]  row_hi_reg;
    logic [8:0]  col_reg;
    logic [8:0]  row_reg;

    logic        v1_reg;
    logic [38:0] dx2_reg;
    logic [38:0] dy2_reg;
    logic [17:0] yw_reg;
    logic [8:0]  s1_col_reg;
    logic [8:0]  s1_row_reg;

    logic        v2_reg;
    logic        s2_inside_reg;
    logic [8:0]  s2_col_reg;
    logic [8:0]  s2_row_reg;

    logic [1:0]  verdict_reg;
    logic [7:0]  hit_column_reg;
    logic [7:0]  hit_row_reg;
    logic [7:0]  hit_cost_reg;

    // cell writes
    logic          in_store;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign in_store = 32'(cell_index) < GRID_CELLS;
    assign wr_addr  = AW'(cell_index);

    always_ff @(posedge clk)
    begin
        if (cmd.cell_write && in_store)
            grid_mem[wr_addr] <= cell_cost;
        mem_q_reg <= grid_mem[rd_addr];
    end

    // window setup
    logic [8:0]                 w_clamp;
    logic [8:0]                 h_clamp;
    logic signed [10:0]         cx;
    logic signed [10:0]         cy;
    logic [8:0]                 rc;
    logic signed [BOUND_W-1:0]  rc_s;
    logic signed [BOUND_W-1:0]  wm1;
    logic signed [BOUND_W-1:0]  hm1;
    logic signed [BOUND_W-1:0]  col_lo_s;
    logic signed [BOUND_W-1:0]  col_hi_s;
    logic signed [BOUND_W-1:0]  row_lo_s;
    logic signed [BOUND_W-1:0]  row_hi_s;
    logic signed [BOUND_W-1:0]  col_first;
    logic signed [BOUND_W-1:0]  col_last;
    logic signed [BOUND_W-1:0]  row_first;
    logic signed [BOUND_W-1:0]  row_last;

    always_comb
    begin
        if (cfg.grid_width == 9'd0)
            w_clamp = 9'd1;
        else if (int'(cfg.grid_width) > MAX_WIDTH)
            w_clamp = 9'(MAX_WIDTH);
        else
            w_clamp = cfg.grid_width;

        if (cfg.grid_height == 9'd0)
            h_clamp = 9'd1;
        else if (int'(cfg.grid_height) > MAX_HEIGHT)
            h_clamp = 9'(MAX_HEIGHT);
        else
            h_clamp = cfg.grid_height;

        cx   = rx_reg[18:8];
        cy   = ry_reg[18:8];
        rc   = 9'((17'(cfg.radius_q8) + 17'd255) >> 8);
        rc_s = $signed({3'b000, rc});
        wm1  = $signed({3'b000, w_clamp}) - 12'sd1;
        hm1  = $signed({3'b000, h_clamp}) - 12'sd1;

        col_lo_s = BOUND_W'(cx) - rc_s;
        col_hi_s = BOUND_W'(cx) + rc_s;
        row_lo_s = BOUND_W'(cy) - rc_s;
        row_hi_s = BOUND_W'(cy) + rc_s;

        col_first = (col_lo_s < 12'sd0) ? 12'sd0 : col_lo_s;
        row_first = (row_lo_s < 12'sd0) ? 12'sd0 : row_lo_s;
        col_last  = (col_hi_s > wm1) ? wm1 : col_hi_s;
        row_last  = (row_hi_s > hm1) ? hm1 : row_hi_s;
    end

    // stage 0: offsets and squares
    logic signed [19:0] dx;
    logic signed [19:0] dy;
    logic signed [39:0] dx_sq;
    logic signed [39:0] dy_sq;

    assign dx    = $signed({3'b000, col_reg, 8'h80}) - 20'(rx_reg);
    assign dy    = $signed({3'b000, row_reg, 8'h80}) - 20'(ry_reg);
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    // stage 1: circle test and memory address
    logic [39:0] dist2;
    logic        in_circle;

    assign dist2     = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign in_circle = dist2 <= {8'b0, r2_reg};
    assign rd_addr   = AW'(yw_reg) + AW'(s1_col_reg);

    // stage 2: cost test
    logic is_unknown;
    logic blocks;
    logic hit;

    assign is_unknown = mem_q_reg == COST_UNKNOWN;
    assign blocks     = is_unknown ? cfg.block_unknown_cells
                                   : (mem_q_reg >= cfg.lethal_threshold);
    assign hit        = v2_reg && s2_inside_reg && blocks;

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            rx_reg <= robot_x_q8;
            ry_reg <= robot_y_q8;
        end

        if (cmd.setup)
        begin
            w_reg      <= w_clamp;
            r2_reg     <= 32'(cfg.radius_q8) * 32'(cfg.radius_q8);
            col_lo_reg <= col_first[8:0];
            col_hi_reg <= col_last[8:0];
            row_hi_reg <= row_last[8:0];
            col_reg    <= col_first[8:0];
            row_reg    <= row_first[8:0];
        end
        else if (cmd.issue)
        begin
            if (col_reg == col_hi_reg)
            begin
                col_reg <= col_lo_reg;
                row_reg <= row_reg + 9'd1;
            end
            else
            begin
                col_reg <= col_reg + 9'd1;
            end
        end

        dx2_reg    <= dx_sq[38:0];
        dy2_reg    <= dy_sq[38:0];
        yw_reg     <= 18'(row_reg) * 18'(w_reg);
        s1_col_reg <= col_reg;
        s1_row_reg <= row_reg;

        s2_inside_reg <= in_circle;
        s2_col_reg    <= s1_col_reg;
        s2_row_reg    <= s1_row_reg;

        if (cmd.setup)
        begin
            verdict_reg    <= VERDICT_CLEAR;
            hit_column_reg <= 8'd0;
            hit_row_reg    <= 8'd0;
            hit_cost_reg   <= 8'd0;
        end
        else if (cmd.scanning && hit)
        begin
            verdict_reg    <= is_unknown ? VERDICT_UNKNOWN : VERDICT_LETHAL;
            hit_column_reg <= s2_col_reg[7:0];
            hit_row_reg    <= s2_row_reg[7:0];
            hit_cost_reg   <= mem_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    assign status.empty    = (col_first > col_last) || (row_first > row_last);
    assign status.last     = (col_reg == col_hi_reg) && (row_reg == row_hi_reg);
    assign status.hit      = hit;
    assign status.s1_valid = v1_reg;

    assign verdict    = verdict_reg;
    assign hit_column = hit_column_reg;
    assign hit_row    = hit_row_reg;
    assign hit_cost   = hit_cost_reg;

endmodule

`default_nettype wire

// ----- src/grid_disk_clearance_check_core.sv -----
// Top level of the grid disk clearance check: config registers, controller, datapath.
// Depends on gdcc_pkg, gdcc_regs, gdcc_ctrl, gdcc_datapath and assert_macros.svh.
//
// Usage:
//   Items are offered on start with opcode and the field ports; a transfer takes
//   place at a clock edge with start high and busy low.
//   A cell write (opcode 0) stores cell_cost at cell_index in the same edge; busy
//   stays low, so writes go in at one cell per cycle and give no result.
//   A query (opcode 1) raises busy, sets up the clipped window, then walks its
//   cells one per cycle through a three-stage pipeline (squares, grid read, cost
//   test). done pulses for one cycle with verdict, hit_column, hit_row and
//   hit_cost; the receiver takes it in that cycle and cannot stall it.
//   The result comes from the first blocking cell walked; a query walks at most
//   (2*ceil(radius)+1)^2 cells, none for an empty window. busy drops the cycle
//   after done.
//   Configuration must be written through cfg_write_en/cfg_index/cfg_data only while
//   idle; the block does not enforce it. Reset clears the control state and loads the
//   register defaults; the grid contents are undefined until written.
`default_nettype none

`include "assert_macros.svh"

module grid_disk_clearance_check_core #(
    parameter int MAX_WIDTH  = gdcc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gdcc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [gdcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [15:0]                        cell_index,
    input  logic [7:0]                         cell_cost,
    input  logic signed [18:0]                 robot_x_q8,
    input  logic signed [18:0]                 robot_y_q8,
    output logic                               done,
    output logic [1:0]                         verdict,
    output logic [7:0]                         hit_column,
    output logic [7:0]                         hit_row,
    output logic [7:0]                         hit_cost
);
    import gdcc_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    gdcc_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    gdcc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gdcc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .cell_index (cell_index),
        .cell_cost  (cell_cost),
        .robot_x_q8 (robot_x_q8),
        .robot_y_q8 (robot_y_q8),
        .verdict    (verdict),
        .hit_column (hit_column),
        .hit_row    (hit_row),
        .hit_cost   (hit_cost)
    );

    `GDCC_ASSERT_IMP(a_clear_zero, done && (verdict == VERDICT_CLEAR), (hit_column == 8'd0) && (hit_row == 8'd0) && (hit_cost == 8'd0), "clear result carries a hit")
    `GDCC_ASSERT_IMP(a_unknown_cost, done && (verdict == VERDICT_UNKNOWN), hit_cost == COST_UNKNOWN, "unknown verdict on a known cost")
    `GDCC_ASSERT_NXT(a_query_busy, start && !busy && (opcode == OP_QUERY), busy && !done, "query transfer did not start a scan")
    `GDCC_ASSERT_NXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")

endmodule

`default_nettype wire
